// ===== rtl/pfba_pkg.sv =====
// Shared types and constants for the page frame bitmap allocator.
package pfba_pkg;

  localparam int unsigned FRAME_CNT_DEF = 512;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BIT_W         = 5;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned PAGE_W   = 9;
  localparam int unsigned FRAME_W  = 9;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned RES_W    = 10;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_FRAME     = 2'd1,
    ST_ALREADY_FREE = 2'd2
  } status_t;

  // Operation decided at accept time and carried into the update cycle.
  typedef enum logic [2:0] {
    OP_INIT,
    OP_ALLOC,
    OP_FREE,
    OP_NO_FRAME,
    OP_BAD_FREE,
    OP_NOP
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_MOD
  } state_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PAGE_W-1:0]   page_number;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame_number;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_frames;
  } out_item_t;

endpackage

// ===== rtl/page_frame_bitmap_allocator.sv =====
// Top level of the page frame bitmap allocator.
//
// Keeps one used bit per page frame in a word-wide synchronous map memory plus a
// free-frame count. Each item runs through the states S_IDLE and S_MOD:
// the accept cycle in S_IDLE issues the map read (for alloc, the word is chosen by
// per-word full flags, so the lowest word with a free frame is read directly), and
// S_MOD then merges the word, priority-encodes or tests the bit, writes the word back
// and loads the result register. The next item is taken the cycle after that, even
// if the result still waits for out_ready; a stalled result register holds the block
// in its update cycle. Init goes through the same states with no clearing pass: a
// per-word valid bit marks words written since the last init, and a word that is not
// valid reads as the init pattern (the lowest reserved frames used, saturated at the
// frame count). The reserved_r register is written through the cfg port, which is
// always ready; write it only while no item is in flight. Status codes: ok, no free
// frame, frame already free (also given for a frame number at or above the frame
// count).
module page_frame_bitmap_allocator #(
  parameter int unsigned FRAME_CNT = pfba_pkg::FRAME_CNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pfba_pkg::RES_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pfba_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pfba_pkg::out_item_t          out_data
);

  localparam int unsigned WORD_W    = pfba_pkg::WORD_W;
  localparam int unsigned BIT_W     = pfba_pkg::BIT_W;
  localparam int unsigned MAP_WORDS = (FRAME_CNT + WORD_W - 1) / WORD_W;
  localparam int unsigned WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned CNT_W     = $clog2(FRAME_CNT + 1);
  localparam int unsigned BASE_W    = CNT_W + 1;
  localparam int unsigned CMP_W     = (CNT_W > pfba_pkg::RES_W) ? CNT_W : pfba_pkg::RES_W;
  localparam int unsigned PAD_BITS  = FRAME_CNT % WORD_W;
  // Bits of the last word that lie beyond the last frame; they count as used.
  localparam logic [WORD_W-1:0] LAST_PAD =
    (PAD_BITS == 0) ? '0 : ~((WORD_W'(1) << PAD_BITS) - WORD_W'(1));

  // Word w as init leaves it: frames below n are used.
  function automatic logic [WORD_W-1:0] init_word(input logic [CNT_W-1:0] n,
                                                 input logic [WIDX_W-1:0] w);
    logic [BASE_W-1:0] base;
    logic [BASE_W-1:0] n_ext;
    logic [BASE_W-1:0] diff;
    logic [WORD_W-1:0] res;
    base  = BASE_W'(w) << BIT_W;
    n_ext = BASE_W'(n);
    diff  = n_ext - base;
    if (n_ext >= base + BASE_W'(WORD_W)) begin
      res = '1;
    end else if (n_ext > base) begin
      res = (WORD_W'(1) << diff[BIT_W-1:0]) - WORD_W'(1);
    end else begin
      res = '0;
    end
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] pad_of(input logic [WIDX_W-1:0] w);
    return (w == WIDX_W'(MAP_WORDS - 1)) ? LAST_PAD : '0;
  endfunction

  // Control state
  pfba_pkg::state_t        state_r, state_nxt;
  pfba_pkg::op_t           op_r, op_nxt;
  logic [WIDX_W-1:0]       word_r, word_nxt;
  logic [BIT_W-1:0]        bit_r, bit_nxt;
  logic [CNT_W-1:0]        n_init_r, n_init_nxt;
  logic [pfba_pkg::RES_W-1:0] reserved_r, reserved_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [MAP_WORDS-1:0]    full_r, full_nxt;
  logic [MAP_WORDS-1:0]    valid_r, valid_nxt;
  logic                    out_valid_r, out_valid_nxt;
  pfba_pkg::out_item_t     out_r, out_nxt;

  // Map memory port
  logic                    rd_en;
  logic [WIDX_W-1:0]       rd_addr;
  logic [WORD_W-1:0]       rd_data;
  logic                    wr_en;
  logic [WORD_W-1:0]       wr_data;

  // Datapath
  logic                    accept;
  logic                    finish;
  logic [CMP_W-1:0]        page_ext;
  logic                    page_ok;
  logic                    nf_found;
  logic [WIDX_W-1:0]       nf_idx;
  logic [CNT_W-1:0]        n_sat;
  logic [MAP_WORDS-1:0]    full_init;
  logic [WORD_W-1:0]       word_eff;
  logic [WORD_W-1:0]       pad;
  logic [WORD_W-1:0]       probe;
  logic [BIT_W-1:0]        lz_idx;
  logic [WORD_W-1:0]       set_word;
  logic [WORD_W-1:0]       clr_word;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == pfba_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign finish    = (state_r == pfba_pkg::S_MOD) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign page_ext = CMP_W'(in_data.page_number);
  assign page_ok  = page_ext < CMP_W'(FRAME_CNT);

  // Lowest word that still has a free frame.
  always_comb begin
    nf_found = 1'b0;
    nf_idx   = '0;
    for (int i = MAP_WORDS - 1; i >= 0; i--) begin
      if (!full_r[i]) begin
        nf_found = 1'b1;
        nf_idx   = WIDX_W'(i);
      end
    end
  end

  // Saturated reservation and the full flags init leaves behind.
  always_comb begin
    if (CMP_W'(reserved_r) > CMP_W'(FRAME_CNT)) begin
      n_sat = CNT_W'(FRAME_CNT);
    end else begin
      n_sat = CNT_W'(reserved_r);
    end
    for (int i = 0; i < MAP_WORDS; i++) begin
      full_init[i] = ((init_word(n_sat, WIDX_W'(i)) | pad_of(WIDX_W'(i))) == '1);
    end
  end

  // Current view of the word under update.
  always_comb begin
    word_eff = valid_r[word_r] ? rd_data : init_word(n_init_r, word_r);
    pad      = pad_of(word_r);
    probe    = word_eff | pad;
    lz_idx   = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!probe[b]) begin
        lz_idx = BIT_W'(b);
      end
    end
    set_word = word_eff | (WORD_W'(1) << lz_idx);
    clr_word = word_eff & ~(WORD_W'(1) << bit_r);
  end

  // Configuration register
  always_comb begin
    reserved_nxt = reserved_r;
    if (cfg_valid && cfg_ready) begin
      reserved_nxt = cfg_data;
    end
  end

  // Sequencer: accept and read, then modify, write back and load the result.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    n_init_nxt    = n_init_r;
    count_nxt     = count_r;
    full_nxt      = full_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = nf_idx;
    wr_en         = 1'b0;
    wr_data       = set_word;

    unique case (state_r)
      pfba_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = pfba_pkg::S_MOD;
          bit_nxt   = page_ext[BIT_W-1:0];
          word_nxt  = nf_idx;
          unique case (pfba_pkg::action_t'(in_data.action))
            pfba_pkg::ACT_INIT: begin
              op_nxt = pfba_pkg::OP_INIT;
            end
            pfba_pkg::ACT_ALLOC: begin
              if ((count_r != '0) && nf_found) begin
                op_nxt  = pfba_pkg::OP_ALLOC;
                rd_en   = 1'b1;
                rd_addr = nf_idx;
              end else begin
                op_nxt = pfba_pkg::OP_NO_FRAME;
              end
            end
            pfba_pkg::ACT_FREE: begin
              if (page_ok) begin
                op_nxt   = pfba_pkg::OP_FREE;
                rd_en    = 1'b1;
                rd_addr  = page_ext[WIDX_W+BIT_W-1:BIT_W];
                word_nxt = page_ext[WIDX_W+BIT_W-1:BIT_W];
              end else begin
                op_nxt = pfba_pkg::OP_BAD_FREE;
              end
            end
            pfba_pkg::ACT_NOP: begin
              op_nxt = pfba_pkg::OP_NOP;
            end
            default: begin
              op_nxt = pfba_pkg::OP_NOP;
            end
          endcase
        end
      end

      pfba_pkg::S_MOD: begin
        if (finish) begin
          state_nxt                = pfba_pkg::S_IDLE;
          out_valid_nxt            = 1'b1;
          out_nxt.frame_number     = '0;
          out_nxt.status           = pfba_pkg::ST_OK;
          unique case (op_r)
            pfba_pkg::OP_INIT: begin
              n_init_nxt = n_sat;
              count_nxt  = CNT_W'(FRAME_CNT) - n_sat;
              valid_nxt  = '0;
              full_nxt   = full_init;
            end
            pfba_pkg::OP_ALLOC: begin
              wr_en                = 1'b1;
              wr_data              = set_word;
              valid_nxt[word_r]    = 1'b1;
              full_nxt[word_r]     = ((set_word | pad) == '1);
              count_nxt            = count_r - CNT_W'(1);
              out_nxt.frame_number = pfba_pkg::FRAME_W'({word_r, lz_idx});
            end
            pfba_pkg::OP_FREE: begin
              if (word_eff[bit_r]) begin
                wr_en             = 1'b1;
                wr_data           = clr_word;
                valid_nxt[word_r] = 1'b1;
                full_nxt[word_r]  = 1'b0;
                if (count_r < CNT_W'(FRAME_CNT)) begin
                  count_nxt = count_r + CNT_W'(1);
                end
              end else begin
                out_nxt.status = pfba_pkg::ST_ALREADY_FREE;
              end
            end
            pfba_pkg::OP_NO_FRAME: begin
              out_nxt.status = pfba_pkg::ST_NO_FRAME;
            end
            pfba_pkg::OP_BAD_FREE: begin
              out_nxt.status = pfba_pkg::ST_ALREADY_FREE;
            end
            pfba_pkg::OP_NOP: begin
              out_nxt.status = pfba_pkg::ST_OK;
            end
            default: begin
              out_nxt.status = pfba_pkg::ST_OK;
            end
          endcase
          out_nxt.free_frames = pfba_pkg::COUNT_W'(count_nxt);
        end
      end

      default: begin
        state_nxt = pfba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfba_pkg::S_IDLE;
      op_r        <= pfba_pkg::OP_NOP;
      n_init_r    <= '0;
      reserved_r  <= '0;
      count_r     <= CNT_W'(FRAME_CNT);
      full_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      n_init_r    <= n_init_nxt;
      reserved_r  <= reserved_nxt;
      count_r     <= count_nxt;
      full_r      <= full_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    bit_r  <= bit_nxt;
    out_r  <= out_nxt;
  end

  pfba_map_ram #(
    .WORDS (MAP_WORDS),
    .AW    (WIDX_W),
    .DW    (WORD_W)
  ) u_map (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (word_r),
    .wr_data (wr_data)
  );

endmodule

// ===== rtl/pfba_map_ram.sv =====
// Used-bit map storage: one write port, one registered read port.
module pfba_map_ram #(
  parameter int unsigned WORDS = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [WORDS];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
